[design/tkst_pkg.sv]
// Package for the top-k sorted insert table: entry type, operation codes, defaults.
`timescale 1ns / 1ps
package tkst_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 10;

  localparam int SCORE_W = 31;
  localparam int WAVE_W  = 16;
  localparam int STAMP_W = 32;
  localparam int TAG_W   = 64;
  localparam int OP_W    = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_CHECK  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [WAVE_W-1:0]  wave;
    logic [STAMP_W-1:0] stamp;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic commit;
  } cell_ctrl_t;

endpackage

[design/tkst_cell.sv]
// One table cell: holds one entry and takes its upper neighbor's entry on a shift.
`timescale 1ns / 1ps
module tkst_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tkst_pkg::cell_ctrl_t         ctrl,
  input  tkst_pkg::entry_t             item,
  input  logic                         take_prev,
  input  logic                         take_self,
  input  tkst_pkg::entry_t             prev_entry,
  input  logic                         prev_valid,
  output tkst_pkg::entry_t             entry,
  output logic                         valid,
  output logic                         take
);
  import tkst_pkg::*;

  entry_t entry_r, entry_nxt;
  logic   valid_r, valid_nxt;

  // New score lands here if this slot is empty or beaten by it.
  assign take = !valid_r || (item.score > entry_r.score);

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (ctrl.clear) begin
      entry_nxt = '0;
      valid_nxt = 1'b0;
    end else if (ctrl.commit) begin
      if (take_prev) begin
        entry_nxt = prev_entry;
        valid_nxt = prev_valid;
      end else if (take_self) begin
        entry_nxt = item;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
      valid_r <= 1'b0;
    end else begin
      entry_r <= entry_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign entry = entry_r;
  assign valid = valid_r;

endmodule

[design/top_k_sorted_insert_table.sv]
// Top level of the top-k sorted insert table: control sequencer and row of cells.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_stall) carries one operation per transaction:
//   insert, check, clear or read. Result channel (out_valid / out_stall) returns
//   exactly one result transaction per input transaction, in order.
//   The table is a row of TABLE_DEPTH cells kept in descending score order;
//   equal scores keep arrival order.
//   Timing: one item at a time. Each item passes through the evaluate state, then
//   for insert and check the position walk, which steps one cell per cycle up to
//   the insertion position (TABLE_DEPTH when rejected), then the done state;
//   clear and read skip the walk. The result is registered and appears in the
//   cycle after the item's last step.
//   Reset empties the table (all entries zero, fill count zero) and drops any
//   pending result. A stalled result is held in the output register; the next
//   item is accepted meanwhile and its work finishes, then waits until the
//   held result transaction completes.
module top_k_sorted_insert_table #(
  parameter int TABLE_DEPTH = tkst_pkg::DEFAULT_TABLE_DEPTH,
  parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tkst_pkg::OP_W-1:0]    in_operation,
  input  logic [tkst_pkg::SCORE_W-1:0] in_score,
  input  logic [tkst_pkg::WAVE_W-1:0]  in_wave,
  input  logic [tkst_pkg::STAMP_W-1:0] in_stamp,
  input  logic [tkst_pkg::TAG_W-1:0]   in_player_tag,
  input  logic [CNT_W-1:0]             in_read_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_qualifies,
  output logic [CNT_W-1:0]             out_position,
  output logic [CNT_W-1:0]             out_filled,
  output logic                         out_entry_valid,
  output logic [tkst_pkg::SCORE_W-1:0] out_entry_score,
  output logic [tkst_pkg::WAVE_W-1:0]  out_entry_wave,
  output logic [tkst_pkg::STAMP_W-1:0] out_entry_stamp,
  output logic [tkst_pkg::TAG_W-1:0]   out_entry_tag
);
  import tkst_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [OP_W-1:0]        op_r;
  entry_t                 item_r;
  logic [CNT_W-1:0]       ridx_r;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0]       pos_r, pos_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [TABLE_DEPTH-1:0] take_r;

  logic                   out_valid_r, out_valid_nxt;
  logic                   qual_r, qual_nxt;
  logic [CNT_W-1:0]       opos_r, opos_nxt;
  logic                   evalid_r, evalid_nxt;
  entry_t                 edata_r, edata_nxt;

  entry_t                 cell_entry [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] cell_valid;
  logic [TABLE_DEPTH-1:0] cell_take;
  cell_ctrl_t             ctrl;

  logic in_fire, finish, qual_now;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign finish   = (state_r == S_DONE) && !(out_valid_r && out_stall);
  assign qual_now = (pos_r != DEPTH_C);

  assign ctrl.clear  = finish && (op_r == OP_CLEAR);
  assign ctrl.commit = finish && (op_r == OP_INSERT) && qual_now;

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        tkst_cell u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .ctrl       (ctrl),
          .item       (item_r),
          .take_prev  (1'b0),
          .take_self  (take_r[gi]),
          .prev_entry (item_r),
          .prev_valid (1'b0),
          .entry      (cell_entry[gi]),
          .valid      (cell_valid[gi]),
          .take       (cell_take[gi])
        );
      end else begin : g_body
        tkst_cell u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .ctrl       (ctrl),
          .item       (item_r),
          .take_prev  (take_r[gi-1]),
          .take_self  (take_r[gi]),
          .prev_entry (cell_entry[gi-1]),
          .prev_valid (cell_valid[gi-1]),
          .entry      (cell_entry[gi]),
          .valid      (cell_valid[gi]),
          .take       (cell_take[gi])
        );
      end
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    qual_nxt      = qual_r;
    opos_nxt      = opos_r;
    evalid_nxt    = evalid_r;
    edata_nxt     = edata_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        idx_nxt = '0;
        pos_nxt = DEPTH_C;
        if (op_r == OP_INSERT || op_r == OP_CHECK) state_nxt = S_WALK;
        else state_nxt = S_DONE;
      end
      S_WALK: begin
        // Stop at the first cell the score lands in, or past the end.
        if (idx_r == DEPTH_C || take_r[idx_r[IDX_W-1:0]]) begin
          pos_nxt   = idx_r;
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      S_DONE: begin
        if (finish) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          qual_nxt      = 1'b0;
          opos_nxt      = DEPTH_C;
          evalid_nxt    = 1'b0;
          edata_nxt     = '0;
          unique case (op_r)
            OP_INSERT, OP_CHECK: begin
              qual_nxt = qual_now;
              opos_nxt = pos_r;
              if (op_r == OP_INSERT && qual_now && count_r != DEPTH_C)
                count_nxt = count_r + CNT_W'(1);
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              if (ridx_r < count_r) begin
                evalid_nxt = 1'b1;
                edata_nxt  = cell_entry[ridx_r[IDX_W-1:0]];
              end
            end
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r         <= in_operation;
      item_r.score <= in_score;
      item_r.wave  <= in_wave;
      item_r.stamp <= in_stamp;
      item_r.tag   <= in_player_tag;
      ridx_r       <= in_read_index;
    end
    if (state_r == S_EVAL) take_r <= cell_take;
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    qual_r   <= qual_nxt;
    opos_r   <= opos_nxt;
    evalid_r <= evalid_nxt;
    edata_r  <= edata_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_qualifies   = qual_r;
  assign out_position    = opos_r;
  assign out_filled      = count_r;
  assign out_entry_valid = evalid_r;
  assign out_entry_score = edata_r.score;
  assign out_entry_wave  = edata_r.wave;
  assign out_entry_stamp = edata_r.stamp;
  assign out_entry_tag   = edata_r.tag;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("fill count exceeds table depth");

  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_valid & (cell_valid + TABLE_DEPTH'(1))) == '0)
    else $error("valid cells do not form a prefix of the row");

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(count_r))
    else $error("fill count disagrees with valid cells");

  a_qual_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_qualifies |-> out_position < DEPTH_C && !out_entry_valid)
    else $error("qualifying result with bad position or read data");

endmodule

[tb/top_k_sorted_insert_table_checker.sv]
// Checker for the top-k sorted insert table: predicts each result and compares it.
`timescale 1ns / 1ps
module top_k_sorted_insert_table_checker #(
  parameter int DEPTH = tkst_pkg::DEFAULT_TABLE_DEPTH,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [tkst_pkg::OP_W-1:0]    in_operation,
  input  logic [tkst_pkg::SCORE_W-1:0] in_score,
  input  logic [tkst_pkg::WAVE_W-1:0]  in_wave,
  input  logic [tkst_pkg::STAMP_W-1:0] in_stamp,
  input  logic [tkst_pkg::TAG_W-1:0]   in_player_tag,
  input  logic [CNT_W-1:0]             in_read_index,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         out_qualifies,
  input  logic [CNT_W-1:0]             out_position,
  input  logic [CNT_W-1:0]             out_filled,
  input  logic                         out_entry_valid,
  input  logic [tkst_pkg::SCORE_W-1:0] out_entry_score,
  input  logic [tkst_pkg::WAVE_W-1:0]  out_entry_wave,
  input  logic [tkst_pkg::STAMP_W-1:0] out_entry_stamp,
  input  logic [tkst_pkg::TAG_W-1:0]   out_entry_tag,
  output int                           mismatches,
  output int                           pending
);
  import tkst_pkg::*;

  typedef struct packed {
    logic             qualifies;
    logic [CNT_W-1:0] position;
    logic [CNT_W-1:0] filled;
    logic             entry_valid;
    entry_t           entry;
  } score_result_t;

  entry_t        board [DEPTH];
  int            fill;
  score_result_t expected_results [$];

  function automatic void wipe_board();
    for (int i = 0; i < DEPTH; i++) board[i] = '0;
    fill = 0;
  endfunction

  function automatic score_result_t apply_operation(input logic [OP_W-1:0] op,
                                                    input entry_t item,
                                                    input logic [CNT_W-1:0] idx);
    score_result_t r;
    int            slot;
    int            last;
    logic          found;
    r = '0;
    r.position = CNT_W'(DEPTH);
    case (op)
      OP_INSERT, OP_CHECK: begin
        // first place whose score the new one beats, else the end of the fill
        slot = fill;
        found = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
          if (!found && i < fill && item.score > board[i].score) begin
            slot = i;
            found = 1'b1;
          end
        end
        if (slot < DEPTH) begin
          r.qualifies = 1'b1;
          r.position = CNT_W'(slot);
          if (op == OP_INSERT) begin
            last = (fill < DEPTH) ? fill : DEPTH - 1;
            // shift down from the tail, dropping the last entry when full
            for (int i = DEPTH - 1; i > 0; i--) begin
              if (i <= last && i > slot) board[i] = board[i-1];
            end
            board[slot] = item;
            if (fill < DEPTH) fill++;
          end
        end
      end
      OP_CLEAR: wipe_board();
      OP_READ: begin
        if (idx < fill) begin
          r.entry_valid = 1'b1;
          r.entry = board[idx];
        end
      end
      default: ;
    endcase
    r.filled = CNT_W'(fill);
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    score_result_t want;
    entry_t        item;
    if (!rst_n) begin
      expected_results.delete();
      wipe_board();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transaction arrived with nothing expected");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          compare_field("qualifies", want.qualifies, out_qualifies);
          compare_field("position", want.position, out_position);
          compare_field("filled", want.filled, out_filled);
          compare_field("entry_valid", want.entry_valid, out_entry_valid);
          compare_field("entry_score", want.entry.score, out_entry_score);
          compare_field("entry_wave", want.entry.wave, out_entry_wave);
          compare_field("entry_stamp", want.entry.stamp, out_entry_stamp);
          compare_field("entry_tag", want.entry.tag, out_entry_tag);
        end
      end
      if (in_valid && !in_stall) begin
        item.score = in_score;
        item.wave  = in_wave;
        item.stamp = in_stamp;
        item.tag   = in_player_tag;
        expected_results.push_back(apply_operation(in_operation, item, in_read_index));
      end
    end
    pending = expected_results.size();
  end

endmodule

[tb/top_k_sorted_insert_table_test.sv]
// Testbench top for the top-k sorted insert table: stimulus, idle mixes and verdict.
`timescale 1ns / 1ps
module top_k_sorted_insert_table_test;
  import tkst_pkg::*;

  localparam int DEPTH        = DEFAULT_TABLE_DEPTH;
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int RANDOM_ITEMS = 1650;
  localparam int STALE_LIMIT  = 5000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [SCORE_W-1:0] MAX_SCORE = '1;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [OP_W-1:0]    in_operation = OP_READ;
  logic [SCORE_W-1:0] in_score = '0;
  logic [WAVE_W-1:0]  in_wave = '0;
  logic [STAMP_W-1:0] in_stamp = '0;
  logic [TAG_W-1:0]   in_player_tag = '0;
  logic [CNT_W-1:0]   in_read_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_qualifies;
  logic [CNT_W-1:0]   out_position;
  logic [CNT_W-1:0]   out_filled;
  logic               out_entry_valid;
  logic [SCORE_W-1:0] out_entry_score;
  logic [WAVE_W-1:0]  out_entry_wave;
  logic [STAMP_W-1:0] out_entry_stamp;
  logic [TAG_W-1:0]   out_entry_tag;

  int mismatches;
  int pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stale_cycles = 0;
  int op_counts [4] = '{0, 0, 0, 0};

  top_k_sorted_insert_table #(.TABLE_DEPTH(DEPTH)) dut (.*);

  top_k_sorted_insert_table_checker #(.DEPTH(DEPTH)) u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_operation, .in_score, .in_wave,
    .in_stamp, .in_player_tag, .in_read_index, .out_valid, .out_stall,
    .out_qualifies, .out_position, .out_filled, .out_entry_valid,
    .out_entry_score, .out_entry_wave, .out_entry_stamp, .out_entry_tag,
    .mismatches, .pending
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stale_cycles <= 0;
    else stale_cycles <= stale_cycles + 1;
  end

  initial begin
    while (stale_cycles < STALE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Hold the transaction until it is taken; stall is sampled mid-cycle.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [SCORE_W-1:0] score,
                           input logic [WAVE_W-1:0] wave, input logic [STAMP_W-1:0] stamp,
                           input logic [TAG_W-1:0] tag, input logic [CNT_W-1:0] idx);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_score      <= score;
    in_wave       <= wave;
    in_stamp      <= stamp;
    in_player_tag <= tag;
    in_read_index <= idx;
    op_counts[op]++;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
  endtask

  // Pause the sender until every outstanding result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [SCORE_W-1:0] pick_score();
    case ($urandom_range(9))
      0: return '0;
      1: return MAX_SCORE;
      2: return MAX_SCORE - 1'b1;
      3, 4, 5: return SCORE_W'($urandom_range(15));
      default: return SCORE_W'($urandom);
    endcase
  endfunction

  task automatic send_random_item();
    int               pick;
    logic [OP_W-1:0]  op;
    pick = $urandom_range(99);
    if (pick < 2) op = OP_CLEAR;
    else if (pick < 52) op = OP_INSERT;
    else if (pick < 67) op = OP_CHECK;
    else op = OP_READ;
    send_item(op, pick_score(), WAVE_W'($urandom), $urandom, {$urandom, $urandom},
              CNT_W'($urandom_range(DEPTH - 1)));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, ties, full table, drop-off, clear
    send_item(OP_READ, '0, '0, '0, '0, '0);
    send_item(OP_CHECK, '0, '0, '0, '0, '0);
    send_item(OP_INSERT, '0, '0, '0, '0, '0);
    send_item(OP_INSERT, MAX_SCORE, '1, '1, '1, '1);
    send_item(OP_INSERT, MAX_SCORE, 16'h5a5a, 32'h0f0f_0f0f, 64'h0123_4567_89ab_cdef, '0);
    send_item(OP_READ, '0, '0, '0, '0, '0);
    send_item(OP_READ, '0, '0, '0, '0, CNT_W'(1));
    send_item(OP_READ, '0, '0, '0, '0, CNT_W'(2));
    send_item(OP_CHECK, MAX_SCORE, '0, '0, '0, '0);
    for (int k = 0; k < 7; k++) begin
      send_item(OP_INSERT, SCORE_W'(1000 - 100 * k), WAVE_W'(k), STAMP_W'(32'h1000 + k),
                {$urandom, $urandom}, '0);
    end
    send_item(OP_INSERT, '0, '1, '1, '1, '0);
    send_item(OP_CHECK, '0, '0, '0, '0, '0);
    send_item(OP_READ, '0, '0, '0, '0, CNT_W'(DEPTH - 1));
    send_item(OP_INSERT, SCORE_W'(5), 16'h0005, 32'h0000_0005, 64'h5, '0);
    send_item(OP_READ, '0, '0, '0, '0, CNT_W'(DEPTH - 1));
    send_item(OP_CLEAR, '1, '1, '1, '1, '1);
    send_item(OP_READ, '0, '0, '0, '0, '0);
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) send_random_item();
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d inserts, %0d checks, %0d clears and %0d reads",
             op_counts[OP_INSERT], op_counts[OP_CHECK], op_counts[OP_CLEAR],
             op_counts[OP_READ]);
    $display("under four sender idle / receiver stall mixes; mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
